// ===== rtl/core/csc_pkg.sv =====
// ----------------------------------------------------------------------------
// csc_pkg: shared types and constants for the chord circle-center block
// Holds the default coordinate width and the result status codes.
// ----------------------------------------------------------------------------
package csc_pkg;

  localparam int COORD_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_COINCIDENT   = 2'd1,
    ST_SHORT_RADIUS = 2'd2,
    ST_SATURATED    = 2'd3
  } status_t;

endpackage

// ===== rtl/core/csc_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// csc_sqrt_cell: one digit step of two integer square roots
// Resolves one root bit of each operand and hands the partial results on.
// ----------------------------------------------------------------------------
module csc_sqrt_cell import csc_pkg::*; #(
  parameter int K      = COORD_WIDTH_DEF + 1,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [K+1:0]      in_rem_a,
  input  logic [K-1:0]      in_root_a,
  input  logic [2*K-1:0]    in_opnd_a,
  input  logic [K+1:0]      in_rem_b,
  input  logic [K-1:0]      in_root_b,
  input  logic [2*K-1:0]    in_opnd_b,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [K+1:0]      out_rem_a,
  output logic [K-1:0]      out_root_a,
  output logic [2*K-1:0]    out_opnd_a,
  output logic [K+1:0]      out_rem_b,
  output logic [K-1:0]      out_root_b,
  output logic [2*K-1:0]    out_opnd_b,
  output logic [SIDE_W-1:0] out_side
);

  typedef struct packed {
    logic [K+1:0] rem;
    logic [K-1:0] root;
  } digit_t;

  function automatic digit_t step(input logic [K+1:0] rem, input logic [K-1:0] root,
                                  input logic [1:0] pair);
    logic [K+3:0] t;
    logic [K+3:0] trial;
    logic [K+3:0] diff;
    digit_t       d;
    t     = {rem, pair};
    trial = {2'b00, root, 2'b01};
    diff  = t - trial;
    if (t >= trial) begin
      d.rem  = diff[K+1:0];
      d.root = {root[K-2:0], 1'b1};
    end else begin
      d.rem  = t[K+1:0];
      d.root = {root[K-2:0], 1'b0};
    end
    return d;
  endfunction

  digit_t da, db;
  logic   valid_r;
  digit_t a_r, b_r;
  logic [2*K-1:0]    opnd_a_r, opnd_b_r;
  logic [SIDE_W-1:0] side_r;

  always_comb begin
    da = step(in_rem_a, in_root_a, in_opnd_a[2*K-1:2*K-2]);
    db = step(in_rem_b, in_root_b, in_opnd_b[2*K-1:2*K-2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r      <= da;
      b_r      <= db;
      opnd_a_r <= {in_opnd_a[2*K-3:0], 2'b00};
      opnd_b_r <= {in_opnd_b[2*K-3:0], 2'b00};
      side_r   <= in_side;
    end
  end

  assign out_valid  = valid_r;
  assign out_rem_a  = a_r.rem;
  assign out_root_a = a_r.root;
  assign out_opnd_a = opnd_a_r;
  assign out_rem_b  = b_r.rem;
  assign out_root_b = b_r.root;
  assign out_opnd_b = opnd_b_r;
  assign out_side   = side_r;

endmodule

// ===== rtl/core/csc_div_cell.sv =====
// ----------------------------------------------------------------------------
// csc_div_cell: one restoring-division step for two dividends
// Both dividends share one divisor; each cell resolves one quotient bit.
// ----------------------------------------------------------------------------
module csc_div_cell import csc_pkg::*; #(
  parameter int CW     = COORD_WIDTH_DEF,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [CW+2:0]     in_den,
  input  logic [CW+2:0]     in_rem_x,
  input  logic [CW-1:0]     in_qs_x,
  input  logic [CW+2:0]     in_rem_y,
  input  logic [CW-1:0]     in_qs_y,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [CW+2:0]     out_den,
  output logic [CW+2:0]     out_rem_x,
  output logic [CW-1:0]     out_qs_x,
  output logic [CW+2:0]     out_rem_y,
  output logic [CW-1:0]     out_qs_y,
  output logic [SIDE_W-1:0] out_side
);

  typedef struct packed {
    logic [CW+2:0] rem;
    logic [CW-1:0] qs;
  } quo_t;

  function automatic quo_t step(input logic [CW+2:0] rem, input logic [CW-1:0] qs,
                                input logic [CW+2:0] den);
    logic [CW+3:0] t;
    logic [CW+3:0] diff;
    quo_t          r;
    t    = {rem, qs[CW-1]};
    diff = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      r.rem = diff[CW+2:0];
      r.qs  = {qs[CW-2:0], 1'b1};
    end else begin
      r.rem = t[CW+2:0];
      r.qs  = {qs[CW-2:0], 1'b0};
    end
    return r;
  endfunction

  quo_t nx, ny;
  logic valid_r;
  quo_t x_r, y_r;
  logic [CW+2:0]     den_r;
  logic [SIDE_W-1:0] side_r;

  always_comb begin
    nx = step(in_rem_x, in_qs_x, in_den);
    ny = step(in_rem_y, in_qs_y, in_den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= nx;
      y_r    <= ny;
      den_r  <= in_den;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_den   = den_r;
  assign out_rem_x = x_r.rem;
  assign out_qs_x  = x_r.qs;
  assign out_rem_y = y_r.rem;
  assign out_qs_y  = y_r.qs;
  assign out_side  = side_r;

endmodule

// ===== rtl/core/circle_centers_from_chord.sv =====
// ----------------------------------------------------------------------------
// circle_centers_from_chord: both circle centers from a chord and a radius
// Pipelined fixed-point geometry: chord, two square roots, two divisions.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the in_ channel carries points A and B and a radius R, all
//   fixed point with any number of fraction bits (the scale cancels). Every
//   request yields exactly one result on the out_ channel, in request order:
//   the two centers and a status (ok, coincident points, radius too small,
//   saturated). Both channels use valid/ready.
//   The pipeline has three setup stages, COORD_WIDTH+1 square-root cells, two
//   numerator stages, COORD_WIDTH division cells and the output register.
//   Throughput is one request per cycle while the receiver does not stall,
//   set by the cell chains, which advance one step every cycle without a stall.
//   The whole pipeline advances as one: when the receiver stalls with a
//   result held in the output register, every stage holds and in_ready
//   drops; it rises again in the cycle the result is taken.
//   Synchronous reset clears all valid flags; no results are in flight after.
// ----------------------------------------------------------------------------
module circle_centers_from_chord import csc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_WIDTH-1:0] in_start_x,
  input  logic [COORD_WIDTH-1:0] in_start_y,
  input  logic [COORD_WIDTH-1:0] in_end_x,
  input  logic [COORD_WIDTH-1:0] in_end_y,
  input  logic [COORD_WIDTH-2:0] in_radius,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_WIDTH-1:0] out_center1_x,
  output logic [COORD_WIDTH-1:0] out_center1_y,
  output logic [COORD_WIDTH-1:0] out_center2_x,
  output logic [COORD_WIDTH-1:0] out_center2_y,
  output logic [1:0]             out_status
);

  localparam int CW     = COORD_WIDTH;
  localparam int MW     = CW + 1;           // magnitude of a coordinate difference
  localparam int K      = MW;               // root bits, one cell each
  localparam int DW     = CW + 3;           // divisor and partial remainder
  localparam int NW     = 2 * CW + 3;       // dividend
  localparam int SQ_SW  = 2 * MW + 2 + 2 * CW + 2;
  localparam int DV_SW  = 2 + 2 * CW + 2;

  // Global advance: hold everything while a result waits on a stalled receiver.
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Stage 1: chord components, their magnitudes and signs, midpoint.
  logic signed [MW-1:0] dx, dy, sum_x, sum_y;
  logic v1_r;
  logic [MW-1:0] mdx1_r, mdy1_r;
  logic          ndx1_r, ndy1_r;
  logic [CW-1:0] mx1_r, my1_r;
  logic [CW-2:0] r1_r;

  always_comb begin
    dx    = $signed({in_end_x[CW-1], in_end_x}) - $signed({in_start_x[CW-1], in_start_x});
    dy    = $signed({in_end_y[CW-1], in_end_y}) - $signed({in_start_y[CW-1], in_start_y});
    sum_x = $signed({in_end_x[CW-1], in_end_x}) + $signed({in_start_x[CW-1], in_start_x});
    sum_y = $signed({in_end_y[CW-1], in_end_y}) + $signed({in_start_y[CW-1], in_start_y});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mdx1_r <= dx[MW-1] ? MW'(-dx) : MW'(dx);
      mdy1_r <= dy[MW-1] ? MW'(-dy) : MW'(dy);
      ndx1_r <= dx[MW-1];
      ndy1_r <= dy[MW-1];
      // Floor of half the sum: drop the low bit of the two's complement sum.
      mx1_r  <= sum_x[CW:1];
      my1_r  <= sum_y[CW:1];
      r1_r   <= in_radius;
    end
  end

  // Stage 2: squares of the chord components and of the doubled radius.
  logic v2_r;
  logic [2*CW-1:0] sqx2_r, sqy2_r, r42_r;
  logic [MW-1:0] mdx2_r, mdy2_r;
  logic          ndx2_r, ndy2_r;
  logic [CW-1:0] mx2_r, my2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx2_r <= (2*CW)'(mdx1_r * mdx1_r);
      sqy2_r <= (2*CW)'(mdy1_r * mdy1_r);
      r42_r  <= {(2*CW-2)'(r1_r * r1_r), 2'b00};
      mdx2_r <= mdx1_r;
      mdy2_r <= mdy1_r;
      ndx2_r <= ndx1_r;
      ndy2_r <= ndy1_r;
      mx2_r  <= mx1_r;
      my2_r  <= my1_r;
    end
  end

  // Stage 3: squared chord length, classify, radicand for the offset root.
  logic [2*K-1:0] d2;
  logic [2*CW-1:0] q_diff;
  status_t st_pre;
  logic v3_r;
  logic [2*K-1:0] d2_3_r, q3_r;
  logic [SQ_SW-1:0] side3_r;

  always_comb begin
    d2     = (2*K)'(sqx2_r) + (2*K)'(sqy2_r);
    q_diff = r42_r - (2*CW)'(d2);
    if (d2 == '0) begin
      st_pre = ST_COINCIDENT;
    end else if ((2*K)'(r42_r) < d2) begin
      st_pre = ST_SHORT_RADIUS;
    end else begin
      st_pre = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_3_r  <= d2;
      q3_r    <= (2*K)'(q_diff);
      side3_r <= {mdx2_r, mdy2_r, ndx2_r, ndy2_r, mx2_r, my2_r, st_pre};
    end
  end

  // Square-root chain: chord length and twice the center distance.
  logic [K:0]       sq_v;
  logic [K+1:0]     sq_rem_a  [0:K];
  logic [K-1:0]     sq_root_a [0:K];
  logic [2*K-1:0]   sq_opnd_a [0:K];
  logic [K+1:0]     sq_rem_b  [0:K];
  logic [K-1:0]     sq_root_b [0:K];
  logic [2*K-1:0]   sq_opnd_b [0:K];
  logic [SQ_SW-1:0] sq_side   [0:K];

  assign sq_v[0]      = v3_r;
  assign sq_rem_a[0]  = '0;
  assign sq_root_a[0] = '0;
  assign sq_opnd_a[0] = d2_3_r;
  assign sq_rem_b[0]  = '0;
  assign sq_root_b[0] = '0;
  assign sq_opnd_b[0] = q3_r;
  assign sq_side[0]   = side3_r;

  for (genvar i = 0; i < K; i++) begin : g_sqrt
    csc_sqrt_cell #(.K(K), .SIDE_W(SQ_SW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (sq_v[i]),
      .in_rem_a  (sq_rem_a[i]),
      .in_root_a (sq_root_a[i]),
      .in_opnd_a (sq_opnd_a[i]),
      .in_rem_b  (sq_rem_b[i]),
      .in_root_b (sq_root_b[i]),
      .in_opnd_b (sq_opnd_b[i]),
      .in_side   (sq_side[i]),
      .out_valid (sq_v[i+1]),
      .out_rem_a (sq_rem_a[i+1]),
      .out_root_a(sq_root_a[i+1]),
      .out_opnd_a(sq_opnd_a[i+1]),
      .out_rem_b (sq_rem_b[i+1]),
      .out_root_b(sq_root_b[i+1]),
      .out_opnd_b(sq_opnd_b[i+1]),
      .out_side  (sq_side[i+1])
    );
  end

  // Unpack the chain tail.
  logic [MW-1:0] mdx_s, mdy_s;
  logic          ndx_s, ndy_s;
  logic [CW-1:0] mx_s, my_s;
  logic [1:0]    st_s;
  logic [CW-1:0] hq;

  assign {mdx_s, mdy_s, ndx_s, ndy_s, mx_s, my_s, st_s} = sq_side[K];
  assign hq = sq_root_b[K][CW-1:0];

  // Product stage: component magnitude times twice the center distance.
  logic p1v_r;
  logic [2*CW:0] prodx_r, prody_r;
  logic [K-1:0]  dq1_r;
  logic [DV_SW-1:0] sidep1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1v_r <= 1'b0;
    end else if (en) begin
      p1v_r <= sq_v[K];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prodx_r  <= (2*CW+1)'(mdy_s * hq);  // x offset follows dy
      prody_r  <= (2*CW+1)'(mdx_s * hq);
      dq1_r    <= sq_root_a[K];
      sidep1_r <= {ndx_s, ndy_s, mx_s, my_s, st_s};
    end
  end

  // Dividend stage: 2*prod + 2*d over 4*d rounds half away from zero.
  logic [NW-1:0] numx, numy;
  logic p2v_r;
  logic [DW-1:0] den2_r, remx2_r, remy2_r;
  logic [CW-1:0] qsx2_r, qsy2_r;
  logic [DV_SW-1:0] sidep2_r;

  always_comb begin
    numx = {prodx_r, 1'b0} + NW'({dq1_r, 1'b0});
    numy = {prody_r, 1'b0} + NW'({dq1_r, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2v_r <= 1'b0;
    end else if (en) begin
      p2v_r <= p1v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den2_r   <= {dq1_r, 2'b00};
      // The quotient fits CW bits, so the top bits start below the divisor.
      remx2_r  <= numx[NW-1:CW];
      qsx2_r   <= numx[CW-1:0];
      remy2_r  <= numy[NW-1:CW];
      qsy2_r   <= numy[CW-1:0];
      sidep2_r <= sidep1_r;
    end
  end

  // Division chain: one quotient bit per cell for both offsets.
  logic [CW:0]      dv_v;
  logic [DW-1:0]    dv_den   [0:CW];
  logic [DW-1:0]    dv_rem_x [0:CW];
  logic [CW-1:0]    dv_qs_x  [0:CW];
  logic [DW-1:0]    dv_rem_y [0:CW];
  logic [CW-1:0]    dv_qs_y  [0:CW];
  logic [DV_SW-1:0] dv_side  [0:CW];

  assign dv_v[0]     = p2v_r;
  assign dv_den[0]   = den2_r;
  assign dv_rem_x[0] = remx2_r;
  assign dv_qs_x[0]  = qsx2_r;
  assign dv_rem_y[0] = remy2_r;
  assign dv_qs_y[0]  = qsy2_r;
  assign dv_side[0]  = sidep2_r;

  for (genvar j = 0; j < CW; j++) begin : g_div
    csc_div_cell #(.CW(CW), .SIDE_W(DV_SW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (dv_v[j]),
      .in_den   (dv_den[j]),
      .in_rem_x (dv_rem_x[j]),
      .in_qs_x  (dv_qs_x[j]),
      .in_rem_y (dv_rem_y[j]),
      .in_qs_y  (dv_qs_y[j]),
      .in_side  (dv_side[j]),
      .out_valid(dv_v[j+1]),
      .out_den  (dv_den[j+1]),
      .out_rem_x(dv_rem_x[j+1]),
      .out_qs_x (dv_qs_x[j+1]),
      .out_rem_y(dv_rem_y[j+1]),
      .out_qs_y (dv_qs_y[j+1]),
      .out_side (dv_side[j+1])
    );
  end

  // Output stage: signed offsets, add to the midpoint, saturate.
  function automatic logic [CW:0] clamp(input logic [CW+1:0] v);
    logic [CW:0] r;  // {saturated flag, value}
    if (v[CW+1:CW-1] == 3'b000 || v[CW+1:CW-1] == 3'b111) begin
      r = {1'b0, v[CW-1:0]};
    end else if (v[CW+1]) begin
      r = {1'b1, 1'b1, {(CW-1){1'b0}}};
    end else begin
      r = {1'b1, 1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

  logic          ndx_d, ndy_d;
  logic [CW-1:0] mx_d, my_d;
  logic [1:0]    st_d;
  logic signed [CW+1:0] ox, oy, mxe, mye;
  logic [CW:0] c0, c1, c2, c3;
  status_t st_fin;
  logic [CW-1:0] c1x_r, c1y_r, c2x_r, c2y_r;
  logic [1:0]    st_r;

  assign {ndx_d, ndy_d, mx_d, my_d, st_d} = dv_side[CW];

  always_comb begin
    ox  = ndy_d ? -$signed({2'b00, dv_qs_x[CW]}) : $signed({2'b00, dv_qs_x[CW]});
    oy  = ndx_d ? -$signed({2'b00, dv_qs_y[CW]}) : $signed({2'b00, dv_qs_y[CW]});
    mxe = $signed({{2{mx_d[CW-1]}}, mx_d});
    mye = $signed({{2{my_d[CW-1]}}, my_d});
    c0  = clamp(mxe + ox);
    c1  = clamp(mye - oy);
    c2  = clamp(mxe - ox);
    c3  = clamp(mye + oy);
    if (st_d != ST_OK) begin
      st_fin = status_t'(st_d);
    end else if (c0[CW] || c1[CW] || c2[CW] || c3[CW]) begin
      st_fin = ST_SATURATED;
    end else begin
      st_fin = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Drop the centers for coincident points and short radius.
      c1x_r <= (st_d == ST_OK) ? c0[CW-1:0] : '0;
      c1y_r <= (st_d == ST_OK) ? c1[CW-1:0] : '0;
      c2x_r <= (st_d == ST_OK) ? c2[CW-1:0] : '0;
      c2y_r <= (st_d == ST_OK) ? c3[CW-1:0] : '0;
      st_r  <= st_fin;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_center1_x = c1x_r;
  assign out_center1_y = c1y_r;
  assign out_center2_x = c2x_r;
  assign out_center2_y = c2y_r;
  assign out_status    = st_r;

  // Failed geometry reports all centers at zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (st_r == ST_COINCIDENT || st_r == ST_SHORT_RADIUS) |->
      c1x_r == '0 && c1y_r == '0 && c2x_r == '0 && c2y_r == '0)
    else $error("nonzero center on failed geometry");

  // Unsaturated centers are symmetric about the midpoint, so their sums are even.
  a_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && st_r == ST_OK |->
      c1x_r[0] == c2x_r[0] && c1y_r[0] == c2y_r[0])
    else $error("centers not symmetric about the midpoint");

  // A stall freezes the cell chains.
  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(sq_v) && $stable(dv_v))
    else $error("cell chain moved during a stall");

endmodule

// ===== sim/circle_centers_from_chord_test.sv =====
// ----------------------------------------------------------------------------
// circle_centers_from_chord_test: self-checking bench for the chord block
// Drives point pairs and radii through valid/ready with random idling and
// stalls. A scoreboard predicts the two centers and the status of every
// request with exact wide integer math, then compares results in order.
// ----------------------------------------------------------------------------
module circle_centers_from_chord_test;
  import csc_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam int LATENCY = 2 * CW + 7;

  // Kinds of random request
  typedef enum int {
    RQ_NOISE, RQ_REACHABLE, RQ_TANGENT, RQ_COINCIDENT, RQ_SHORT, RQ_WIDE
  } rq_kind_t;

  typedef struct {
    logic signed [CW-1:0] sx, sy, ex, ey;
    logic [CW-2:0]        rad;
  } chord_req_t;

  typedef struct {
    logic [CW-1:0] c1x, c1y, c2x, c2y;
    status_t       st;
  } centers_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts centers for each accepted request, checks results
  // --------------------------------------------------------------------------
  class center_scoreboard;
    centers_t pending_centers[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    static function logic [63:0] root_floor(logic [127:0] n);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if ({64'd0, c} * {64'd0, c} <= n) r = c;
      end
      return r;
    endfunction

    // |comp|*hq/(2*dq) rounded half away from zero, sign of comp
    static function longint chord_offset(longint comp, logic [63:0] hq, logic [63:0] dq);
      logic [127:0] num;
      logic [127:0] m;
      longint       a;
      a = comp < 0 ? -comp : comp;
      num = 128'(a) * 128'(hq);
      m = (2 * num + 2 * 128'(dq)) / (4 * 128'(dq));
      if (m > (128'd1 << 62)) m = 128'd1 << 62;
      return comp < 0 ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    static function logic [CW-1:0] clamp(longint v, ref bit hit);
      if (v > COORD_MAX) begin
        hit = 1;
        return COORD_MAX[CW-1:0];
      end
      if (v < COORD_MIN) begin
        hit = 1;
        return COORD_MIN[CW-1:0];
      end
      return v[CW-1:0];
    endfunction

    static function centers_t predict(chord_req_t q);
      longint       sx, sy, ex, ey, dx, dy, ax, ay, mx, my, ox, oy;
      logic [127:0] d2, r4;
      logic [63:0]  dq, hq;
      bit           hit;
      centers_t     c;
      sx = q.sx; sy = q.sy; ex = q.ex; ey = q.ey;
      dx = ex - sx; dy = ey - sy;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      d2 = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
      r4 = 128'({q.rad, 1'b0}) * 128'({q.rad, 1'b0});
      c = '{default: '0, st: ST_OK};
      hit = 0;
      if (d2 == 0) begin
        c.st = ST_COINCIDENT;
      end else if (r4 < d2) begin
        c.st = ST_SHORT_RADIUS;
      end else begin
        dq = root_floor(d2);
        hq = root_floor(r4 - d2);
        mx = (sx + ex) >>> 1;
        my = (sy + ey) >>> 1;
        ox = chord_offset(dy, hq, dq);
        oy = chord_offset(dx, hq, dq);
        c.c1x = clamp(mx + ox, hit);
        c.c1y = clamp(my - oy, hit);
        c.c2x = clamp(mx - ox, hit);
        c.c2y = clamp(my + oy, hit);
        c.st = hit ? ST_SATURATED : ST_OK;
      end
      return c;
    endfunction

    function void note_request(chord_req_t q);
      pending_centers.push_back(predict(q));
    endfunction

    function void check_result(centers_t got);
      centers_t exp_c;
      if (pending_centers.size() == 0) begin
        $display("%0t: result with none pending: %p", $time, got);
        errors++;
        return;
      end
      exp_c = pending_centers.pop_front();
      if (got.c1x !== exp_c.c1x) begin
        $display("%0t: center1_x exp %h got %h", $time, exp_c.c1x, got.c1x);
        errors++;
      end
      if (got.c1y !== exp_c.c1y) begin
        $display("%0t: center1_y exp %h got %h", $time, exp_c.c1y, got.c1y);
        errors++;
      end
      if (got.c2x !== exp_c.c2x) begin
        $display("%0t: center2_x exp %h got %h", $time, exp_c.c2x, got.c2x);
        errors++;
      end
      if (got.c2y !== exp_c.c2y) begin
        $display("%0t: center2_y exp %h got %h", $time, exp_c.c2y, got.c2y);
        errors++;
      end
      if (got.st !== exp_c.st) begin
        $display("%0t: status exp %s got %s", $time, exp_c.st.name(), got.st.name());
        errors++;
      end
    endfunction
  endclass

  logic          clk = 0;
  logic          rst_n = 0;
  logic          in_valid = 0;
  logic          in_ready;
  logic [CW-1:0] in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic [CW-2:0] in_radius = '0;
  logic          out_valid;
  logic          out_ready = 0;
  logic [CW-1:0] out_center1_x, out_center1_y, out_center2_x, out_center2_y;
  logic [1:0]    out_status;

  center_scoreboard sb = new();

  // Idle percentages, changed per phase by the stimulus
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  circle_centers_from_chord u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_start_x   (in_start_x),
    .in_start_y   (in_start_y),
    .in_end_x     (in_end_x),
    .in_end_y     (in_end_y),
    .in_radius    (in_radius),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_center1_x(out_center1_x),
    .out_center1_y(out_center1_y),
    .out_center2_x(out_center2_x),
    .out_center2_y(out_center2_y),
    .out_status   (out_status)
  );

  // Receiver: random stall per phase; a requested hold-off counts down here
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every accepted result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result('{out_center1_x, out_center1_y, out_center2_x, out_center2_y,
                        status_t'(out_status)});
    end
  end

  // Offer one request, idling first at random; hold it until accepted
  task automatic send_request(chord_req_t q);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid   <= 1;
    in_start_x <= q.sx;
    in_start_y <= q.sy;
    in_end_x   <= q.ex;
    in_end_y   <= q.ey;
    in_radius  <= q.rad;
    do @(posedge clk); while (!in_ready);
    sb.note_request(q);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic send_fields(longint sx, longint sy, longint ex, longint ey, longint r);
    chord_req_t q;
    q.sx = sx[CW-1:0]; q.sy = sy[CW-1:0];
    q.ex = ex[CW-1:0]; q.ey = ey[CW-1:0];
    q.rad = r[CW-2:0];
    send_request(q);
  endtask

  function automatic longint rand_coord();
    return longint'($signed($urandom()));
  endfunction

  // Build a random request; most have a reachable radius so centers get checked
  task automatic send_random();
    rq_kind_t kind;
    longint   sx, sy, dx, dy, k, r, span;
    int       pick;
    pick = $urandom_range(99);
    kind = pick < 10 ? RQ_NOISE : pick < 60 ? RQ_REACHABLE : pick < 70 ? RQ_TANGENT :
           pick < 78 ? RQ_COINCIDENT : pick < 88 ? RQ_SHORT : RQ_WIDE;
    sx = rand_coord();
    sy = rand_coord();
    span = longint'(1) << $urandom_range(29);
    dx = longint'($urandom_range(32'(span))) * ($urandom_range(1) ? 1 : -1);
    dy = longint'($urandom_range(32'(span))) * ($urandom_range(1) ? 1 : -1);
    if ($urandom_range(3) == 0) begin
      sx = sx >>> $urandom_range(31);
      sy = sy >>> $urandom_range(31);
    end
    case (kind)
      RQ_NOISE: begin
        send_fields(sx, sy, rand_coord(), rand_coord(), $urandom());
      end
      RQ_REACHABLE: begin
        r = ((dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy)) / 2 + 1 +
            longint'($urandom_range(32'(span)));
        send_fields(sx, sy, sx + dx, sy + dy, r);
      end
      RQ_TANGENT: begin
        // axis chord of length 2R, or a 6-8-10 chord with R = 5k
        k = longint'($urandom_range(32'(span)));
        if ($urandom_range(1))
          send_fields(sx, sy, sx + 2 * k, sy, k);
        else
          send_fields(sx, sy, sx - 6 * k, sy + 8 * k, 5 * k);
      end
      RQ_COINCIDENT: begin
        send_fields(sx, sy, sx, sy, $urandom());
      end
      RQ_SHORT: begin
        // radius just under or at half the chord
        r = ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx) :
             (dy < 0 ? -dy : dy)) / 2 - $urandom_range(2);
        send_fields(sx, sy, sx + dx, sy + dy, r < 0 ? 0 : r);
      end
      default: begin
        // large radius from wide points: reaches saturation
        send_fields(sx, sy, sx + dx, sy + dy, 64'h7fff_ffff - $urandom_range(1 << 20));
      end
    endcase
  endtask

  task automatic wait_drained();
    while (sb.pending_centers.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: extremes, coincident, short, tangent, saturation, signs
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_fields(0, 0, 0, 0, 0);
    send_fields(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 64'h7fff_ffff);
    send_fields(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 64'h7fff_ffff);
    send_fields(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0);
    send_fields(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 64'h7fff_ffff);
    send_fields(COORD_MIN, 0, COORD_MAX, 0, 64'h7fff_ffff);
    send_fields(0, COORD_MIN, 0, COORD_MAX, 64'h7fff_ffff);
    send_fields(-1, -1, 1, 1, 64'h7fff_ffff);
    send_fields(0, 0, 65536, 0, 32768);
    send_fields(0, 0, 6, 8, 5);
    send_fields(0, 0, 6, 8, 4);
    send_fields(0, 0, -6, -8, 100);
    send_fields(-3, 5, 7, -11, 9);
    send_fields(1, 0, 0, 0, 0);
    send_fields(1, 0, 0, 0, 1);
    send_fields(COORD_MAX, 0, COORD_MAX - 2, 0, 64'h7fff_ffff);
    send_fields(COORD_MIN, 0, COORD_MIN + 2, 0, 64'h7fff_ffff);
    send_fields(0, COORD_MAX, 2, COORD_MAX, 64'h7fff_ffff);
    send_fields(0, COORD_MIN, 2, COORD_MIN, 64'h7fff_ffff);
    send_fields(123456, -654321, 123456, -654321, 64'h7fff_ffff);
    send_fields(-65536, 65536, 65536, -65536, 65536 * 3);

    // Sender pauses until every expected result has come
    drop_valid();
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 31 : phase == 1 ? 49 : 0;
      recv_idle_pct = phase == 0 ? 49 : phase == 1 ? 31 : 0;
      for (int i = 0; i < 600; i++) begin
        // Long receiver hold-off: fill the pipeline and stall the input
        if (i == 300 && phase == 2) hold_cycles = 4 * LATENCY;
        send_random();
      end
    end
    drop_valid();

    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0)
      $display("circle_centers_from_chord_test: done, clean");
    else
      $display("circle_centers_from_chord_test: done, errors");
    $finish;
  end

  initial begin
    #4000000;
    $display("circle_centers_from_chord_test: done, errors");
    $finish;
  end

endmodule
